>>> design/tcc_pkg.sv
package tcc_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic write_cell;
      logic scroll;
   } cursor_ctl_type;

endpackage

>>> design/tcc_screen_ram.sv
module tcc_screen_ram #(
   parameter int DEPTH = tcc_pkg::COLUMNS_DEF * tcc_pkg::ROWS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcc_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcc_pkg::CELL_W-1:0] rd_data
);

   logic [tcc_pkg::CELL_W-1:0] screen_mem [DEPTH];
   logic [tcc_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tcc_cursor.sv
module tcc_cursor #(
   parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcc_pkg::ROWS_DEF,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int ROW_W  = $clog2(ROWS),
   localparam int COL_W  = $clog2(COLUMNS),
   localparam int ADDR_W = $clog2(CELLS)
) (
   input  logic [ROW_W-1:0]           cur_row,
   input  logic [COL_W-1:0]           cur_col,
   input  logic [ADDR_W-1:0]          base,
   input  logic [tcc_pkg::CHAR_W-1:0] char_code,
   output logic [ROW_W-1:0]           next_row,
   output logic [COL_W-1:0]           next_col,
   output logic [ADDR_W-1:0]          wr_addr,
   output tcc_pkg::cursor_ctl_type    ctl
);

   localparam int AW_X = ADDR_W + 1;

   logic [ROW_W:0]   row_x;
   logic [COL_W-1:0] col_n;
   logic [AW_X-1:0]  lin_addr;
   logic [AW_X-1:0]  sum_addr;

   always_comb begin
      row_x          = {1'b0, cur_row};
      col_n          = cur_col;
      ctl.write_cell = 1'b0;
      priority if (char_code == tcc_pkg::CH_NEWLINE) begin
         col_n = '0;
         row_x = row_x + 1'b1;
      end else if (char_code == tcc_pkg::CH_RETURN) begin
         col_n = '0;
      end else if (char_code == tcc_pkg::CH_BACKSPACE) begin
         if (cur_col != '0) begin
            col_n = cur_col - 1'b1;
         end else if (cur_row != '0) begin
            row_x = row_x - 1'b1;
            col_n = COL_W'(COLUMNS - 1);
         end
      end else begin
         ctl.write_cell = 1'b1;
         if (cur_col == COL_W'(COLUMNS - 1)) begin
            col_n = '0;
            row_x = row_x + 1'b1;
         end else begin
            col_n = cur_col + 1'b1;
         end
      end
      ctl.scroll = (row_x == (ROW_W + 1)'(ROWS));
      next_row   = ctl.scroll ? ROW_W'(ROWS - 1) : row_x[ROW_W-1:0];
      next_col   = col_n;
   end

   // The screen is a ring of rows; base is the cell offset of the top row.
   always_comb begin
      lin_addr = AW_X'(cur_row) * AW_X'(COLUMNS) + AW_X'(cur_col);
      sum_addr = lin_addr + AW_X'(base);
      if (sum_addr >= AW_X'(CELLS)) begin
         sum_addr = sum_addr - AW_X'(CELLS);
      end
      wr_addr = sum_addr[ADDR_W-1:0];
   end

endmodule

>>> design/text_console_cursor_and_scroll.sv
// Text console with a cursor, one screen of ROWS x COLUMNS cells held in a
// single-port-write, registered-read memory.
// The request channel carries an operation, a character and a cell address;
// a beat is taken when req_valid is high and req_stall is low. Every request
// gives exactly one response beat with the cursor after the operation and,
// for a read, the addressed cell.
// A put without scroll, a read and an unused code go straight to the finish
// state, which loads the response once the response register is free; the
// next request is taken only after that. A put that scrolls first blanks the
// new bottom row of COLUMNS cells, and a clear blanks all ROWS * COLUMNS cells,
// one cell written per cycle through the memory write port. Scrolling moves
// a top-row offset and copies no cells.
// After reset a clearing pass blanks all ROWS * COLUMNS cells with
// req_stall high; csr writes are taken during it. The attribute register is
// written with csr_write_enable and csr_write_data.
// While rsp_stall is high the response holds; one new request is still taken
// and worked on, and its response waits until the held beat leaves.
module text_console_cursor_and_scroll #(
   parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_operation,
   input  logic [7:0]                 req_char_code,
   input  logic [10:0]                req_cell_address,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [4:0]                 rsp_cursor_row,
   output logic [6:0]                 rsp_cursor_col,
   output logic [15:0]                rsp_cell_value,
   input  logic                       csr_write_enable,
   input  logic [tcc_pkg::ATTR_W-1:0] csr_write_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int AW_X   = (ADDR_W > 11 ? ADDR_W : 11) + 1;
   localparam int ROW_X  = ROW_W > 5 ? ROW_W : 5;
   localparam int COL_X  = COL_W > 7 ? COL_W : 7;

   tcc_pkg::state_type state_ff, state_in;

   logic [tcc_pkg::ATTR_W-1:0] text_attr_ff, text_attr_in;
   logic [ROW_W-1:0]           cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]           cursor_col_ff, cursor_col_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [ADDR_W-1:0]          sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]          sweep_end_ff, sweep_end_in;
   logic [tcc_pkg::ATTR_W-1:0] sweep_attr_ff, sweep_attr_in;
   logic                       cell_sel_ff, cell_sel_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [4:0]                 rsp_row_ff, rsp_row_in;
   logic [6:0]                 rsp_col_ff, rsp_col_in;
   logic [15:0]                rsp_cell_ff, rsp_cell_in;

   logic                        req_accept;
   logic                        rsp_free;
   logic                        sweep_done;
   logic [ROW_W-1:0]            put_row;
   logic [COL_W-1:0]            put_col;
   logic [ADDR_W-1:0]           put_addr;
   tcc_pkg::cursor_ctl_type     put_ctl;
   logic [AW_X-1:0]             rd_addr_x;
   logic [AW_X-1:0]             rd_sum;
   logic                        rd_in_range;
   logic [AW_X-1:0]             base_step;
   logic [ROW_X-1:0]            row_x;
   logic [COL_X-1:0]            col_x;
   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   logic [tcc_pkg::CELL_W-1:0]  mem_wr_data;
   logic                        mem_rd_en;
   logic [tcc_pkg::CELL_W-1:0]  mem_rd_data;

   tcc_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .cur_row   (cursor_row_ff),
      .cur_col   (cursor_col_ff),
      .base      (base_ff),
      .char_code (req_char_code),
      .next_row  (put_row),
      .next_col  (put_col),
      .wr_addr   (put_addr),
      .ctl       (put_ctl)
   );

   tcc_screen_ram #(
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_sum[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign req_stall  = (state_ff != tcc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_done = (sweep_addr_ff == sweep_end_ff);

   always_comb begin
      rd_addr_x   = AW_X'(req_cell_address);
      rd_in_range = (rd_addr_x < AW_X'(CELLS));
      rd_sum      = rd_addr_x + AW_X'(base_ff);
      if (rd_sum >= AW_X'(CELLS)) begin
         rd_sum = rd_sum - AW_X'(CELLS);
      end
      base_step = AW_X'(base_ff) + AW_X'(COLUMNS);
      if (base_step >= AW_X'(CELLS)) begin
         base_step = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcc_pkg::ST_INIT: begin
            if (sweep_done) state_in = tcc_pkg::ST_IDLE;
         end
         tcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               if ((req_operation == tcc_pkg::OP_PUT && put_ctl.scroll) ||
                   req_operation == tcc_pkg::OP_CLEAR) begin
                  state_in = tcc_pkg::ST_SWEEP;
               end else begin
                  state_in = tcc_pkg::ST_FINISH;
               end
            end
         end
         tcc_pkg::ST_SWEEP: begin
            if (sweep_done) state_in = tcc_pkg::ST_FINISH;
         end
         tcc_pkg::ST_FINISH: begin
            if (rsp_free) state_in = tcc_pkg::ST_IDLE;
         end
         default: state_in = tcc_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      text_attr_in  = csr_write_enable ? csr_write_data : text_attr_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      base_in       = base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_end_in  = sweep_end_ff;
      sweep_attr_in = sweep_attr_ff;
      cell_sel_in   = cell_sel_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = sweep_addr_ff;
      mem_wr_data   = {sweep_attr_ff, tcc_pkg::BLANK_CHAR};
      mem_rd_en     = 1'b0;
      row_x         = ROW_X'(cursor_row_ff);
      col_x         = COL_X'(cursor_col_ff);

      unique case (state_ff)
         tcc_pkg::ST_INIT, tcc_pkg::ST_SWEEP: begin
            mem_wr_en = 1'b1;
            if (!sweep_done) sweep_addr_in = sweep_addr_ff + 1'b1;
         end
         tcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               cell_sel_in = (req_operation == tcc_pkg::OP_READ) && rd_in_range;
               mem_rd_en   = (req_operation == tcc_pkg::OP_READ) && rd_in_range;
               unique case (req_operation)
                  tcc_pkg::OP_PUT: begin
                     mem_wr_en     = put_ctl.write_cell;
                     mem_wr_addr   = put_addr;
                     mem_wr_data   = {text_attr_ff, req_char_code};
                     cursor_row_in = put_row;
                     cursor_col_in = put_col;
                     if (put_ctl.scroll) begin
                        // The old top row becomes the new, blank bottom row.
                        base_in       = base_step[ADDR_W-1:0];
                        sweep_addr_in = base_ff;
                        sweep_end_in  = base_ff + ADDR_W'(COLUMNS - 1);
                        sweep_attr_in = text_attr_ff;
                     end
                  end
                  tcc_pkg::OP_CLEAR: begin
                     cursor_row_in = '0;
                     cursor_col_in = '0;
                     base_in       = '0;
                     sweep_addr_in = '0;
                     sweep_end_in  = ADDR_W'(CELLS - 1);
                     sweep_attr_in = text_attr_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tcc_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_x[4:0];
               rsp_col_in   = col_x[6:0];
               rsp_cell_in  = cell_sel_ff ? mem_rd_data : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcc_pkg::ST_INIT;
         text_attr_ff  <= tcc_pkg::RESET_ATTR;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_end_ff  <= ADDR_W'(CELLS - 1);
         sweep_attr_ff <= tcc_pkg::RESET_ATTR;
         cell_sel_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         text_attr_ff  <= text_attr_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_end_ff  <= sweep_end_in;
         sweep_attr_ff <= sweep_attr_in;
         cell_sel_ff   <= cell_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_value = rsp_cell_ff;

   a_cursor_on_screen : assert property (@(posedge clock) disable iff (reset)
      (cursor_row_ff < ROW_W'(ROWS - 1)) || (cursor_row_ff == ROW_W'(ROWS - 1)))
      else $error("cursor row is off the screen");

   a_sweep_in_bounds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcc_pkg::ST_SWEEP || state_ff == tcc_pkg::ST_INIT) |->
      (sweep_addr_ff <= sweep_end_ff))
      else $error("blanking sweep ran past its last cell");

   a_base_row_aligned : assert property (@(posedge clock) disable iff (reset)
      (AW_X'(base_ff) + AW_X'(COLUMNS)) <= AW_X'(CELLS))
      else $error("top row offset is outside the screen");

   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tcc_pkg::ST_FINISH))
      else $error("response loaded outside the finish state");

   a_scroll_sweeps : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_operation == tcc_pkg::OP_PUT && put_ctl.scroll) |=>
      (state_ff == tcc_pkg::ST_SWEEP && cursor_row_ff == ROW_W'(ROWS - 1)))
      else $error("scroll did not start a row blanking sweep");

endmodule
